/* rtl/assert_macros.svh */
// assertion macros for the rtl modules, included by the top-level decoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RCSW_ASSERT(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);
`define RCSW_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define RCSW_ASSERT(label, expr, msg)
`define RCSW_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

/* rtl/rcsw_pkg.sv */
// shared types and constants of the rc switch mode button decoder
package rcsw_pkg;

    localparam int CHAN_W = 11;
    localparam int MODE_W = 4;
    localparam int BTN_W  = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MAJORITY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_BELOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UP_ABOVE   = 2'd2;

    localparam logic [CHAN_W-1:0] MAJORITY_RST  = 11'd1075;
    localparam logic [CHAN_W-1:0] DOWN_BELOW_RST = 11'd583;
    localparam logic [CHAN_W-1:0] UP_ABOVE_RST   = 11'd1315;

    typedef enum logic [1:0] {
        POS_DOWN = 2'd0,
        POS_MID  = 2'd1,
        POS_UP   = 2'd2
    } t_pos;

    // one history slot: the three averaged channels
    typedef struct packed {
        logic [CHAN_W-1:0] left;
        logic [CHAN_W-1:0] right;
        logic [CHAN_W-1:0] sel;
    } t_sample;

    typedef struct packed {
        logic [MODE_W-1:0] mode_index;
        logic [BTN_W-1:0]  mode_buttons;
        logic              left_pressed;
        logic              right_pressed;
        logic              indicator_on;
        logic [CHAN_W-1:0] select_average;
    } t_result;

endpackage

/* rtl/rcsw_cell.sv */
// one slot of the history chain, shifts its sample to the next slot on each transfer
module rcsw_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  rcsw_pkg::t_sample i_sample,
    output rcsw_pkg::t_sample o_sample
);

    rcsw_pkg::t_sample r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_shift) begin
            r_sample <= i_sample;
        end
    end

    assign o_sample = r_sample;

endmodule

/* rtl/rcsw_avg_div.sv */
// two-stage divide of a window sum by the window depth via reciprocal multiply
module rcsw_avg_div #(
    parameter int WINDOW_DEPTH = 10,
    localparam int SUM_W = rcsw_pkg::CHAN_W + $clog2(WINDOW_DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [SUM_W-1:0]            i_sum,
    output logic [rcsw_pkg::CHAN_W-1:0] o_avg
);

    localparam logic [SUM_W-1:0] RECIP   = SUM_W'((2 ** SUM_W) / WINDOW_DEPTH);
    localparam logic [SUM_W-1:0] DIVISOR = SUM_W'(WINDOW_DEPTH);

    logic [2*SUM_W-1:0]          n_prod;
    logic [2*SUM_W-1:0]          r_prod;
    logic [SUM_W-1:0]            r_sum;
    logic [SUM_W-1:0]            q_est;
    logic [SUM_W-1:0]            q_times_d;
    logic [SUM_W-1:0]            rem;
    logic [SUM_W-1:0]            q_fix;
    logic [rcsw_pkg::CHAN_W-1:0] r_avg;

    assign n_prod = {{SUM_W{1'b0}}, i_sum} * {{SUM_W{1'b0}}, RECIP};

    // floor reciprocal leaves the estimate at most one below the quotient
    assign q_est     = r_prod[2*SUM_W-1:SUM_W];
    assign q_times_d = q_est * DIVISOR;
    assign rem       = r_sum - q_times_d;
    assign q_fix     = (rem >= DIVISOR) ? q_est + SUM_W'(1) : q_est;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_sum  <= i_sum;
            r_avg  <= q_fix[rcsw_pkg::CHAN_W-1:0];
        end
    end

    assign o_avg = r_avg;

endmodule

/* rtl/rc_switch_mode_button_decoder.sv */
// top level: history chain, running sums, averaging pipeline, mode latch and output skid
// Takes one frame of five channel values per cycle unless held off, and gives one result per frame, in order.
// The three averaged channels shift through a chain of WINDOW_DEPTH cells that start cleared,
// with a running sum per channel updated on each input transfer. Each frame then moves through
// registers in order: the running sum is taken at the transfer itself, the reciprocal
// multiply and remainder correction divide by the window depth, and the classification,
// mode latch and output register come last.
// Throughput is one frame per cycle; a stalled output fills a one-entry skid register and
// only then holds off the input.
// Configuration writes are taken in any cycle and should only be issued while the block is idle.
module rc_switch_mode_button_decoder #(
    parameter int WINDOW_DEPTH = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rcsw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rcsw_pkg::CHAN_W-1:0]         i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [rcsw_pkg::CHAN_W-1:0]         i_left_switch_value,
    input  logic [rcsw_pkg::CHAN_W-1:0]         i_right_switch_value,
    input  logic [rcsw_pkg::CHAN_W-1:0]         i_select_value,
    input  logic [rcsw_pkg::CHAN_W-1:0]         i_left_button_value,
    input  logic [rcsw_pkg::CHAN_W-1:0]         i_right_button_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [rcsw_pkg::MODE_W-1:0]         o_mode_index,
    output logic [rcsw_pkg::BTN_W-1:0]          o_mode_buttons,
    output logic                                o_left_pressed,
    output logic                                o_right_pressed,
    output logic                                o_indicator_on,
    output logic [rcsw_pkg::CHAN_W-1:0]         o_select_average
);

    `include "assert_macros.svh"

    localparam int SUM_W = rcsw_pkg::CHAN_W + $clog2(WINDOW_DEPTH);

    // configuration registers
    logic [rcsw_pkg::CHAN_W-1:0] r_majority;
    logic [rcsw_pkg::CHAN_W-1:0] r_down_below;
    logic [rcsw_pkg::CHAN_W-1:0] r_up_above;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_majority   <= rcsw_pkg::MAJORITY_RST;
            r_down_below <= rcsw_pkg::DOWN_BELOW_RST;
            r_up_above   <= rcsw_pkg::UP_ABOVE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rcsw_pkg::REG_MAJORITY:   r_majority   <= i_cfg_data;
                rcsw_pkg::REG_DOWN_BELOW: r_down_below <= i_cfg_data;
                rcsw_pkg::REG_UP_ABOVE:   r_up_above   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // pipeline control
    logic en;
    logic in_xfer;
    logic push;
    logic pop;
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_out_valid;
    logic r_skid_full;

    assign en      = !r_skid_full;
    assign o_ready = en;
    assign in_xfer = i_valid && en;
    assign push    = en && r_v3;
    assign pop     = r_out_valid && i_ready;

    // history chain
    rcsw_pkg::t_sample chain [0:WINDOW_DEPTH];

    assign chain[0] = '{left: i_left_switch_value, right: i_right_switch_value,
                        sel: i_select_value};

    for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
        rcsw_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (in_xfer),
            .i_sample (chain[g]),
            .o_sample (chain[g+1])
        );
    end

    // running window sums: add the new sample, drop the one leaving the chain
    logic [SUM_W-1:0] r_sum_l;
    logic [SUM_W-1:0] r_sum_r;
    logic [SUM_W-1:0] r_sum_s;
    logic [SUM_W-1:0] n_sum_l;
    logic [SUM_W-1:0] n_sum_r;
    logic [SUM_W-1:0] n_sum_s;

    assign n_sum_l = r_sum_l + SUM_W'(i_left_switch_value) - SUM_W'(chain[WINDOW_DEPTH].left);
    assign n_sum_r = r_sum_r + SUM_W'(i_right_switch_value) - SUM_W'(chain[WINDOW_DEPTH].right);
    assign n_sum_s = r_sum_s + SUM_W'(i_select_value) - SUM_W'(chain[WINDOW_DEPTH].sel);

    logic [2:0] r_lp;
    logic [2:0] r_rp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_l <= '0;
            r_sum_r <= '0;
            r_sum_s <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
        end else if (en) begin
            if (in_xfer) begin
                r_sum_l <= n_sum_l;
                r_sum_r <= n_sum_r;
                r_sum_s <= n_sum_s;
            end
            r_v1 <= in_xfer;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // button compares travel alongside the divide
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lp <= {r_lp[1:0], i_left_button_value > r_majority};
            r_rp <= {r_rp[1:0], i_right_button_value > r_majority};
        end
    end

    logic [rcsw_pkg::CHAN_W-1:0] avg_l;
    logic [rcsw_pkg::CHAN_W-1:0] avg_r;
    logic [rcsw_pkg::CHAN_W-1:0] avg_s;

    rcsw_avg_div #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_div_l (
        .i_clk (i_clk), .i_en (en), .i_sum (r_sum_l), .o_avg (avg_l)
    );
    rcsw_avg_div #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_div_r (
        .i_clk (i_clk), .i_en (en), .i_sum (r_sum_r), .o_avg (avg_r)
    );
    rcsw_avg_div #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_div_s (
        .i_clk (i_clk), .i_en (en), .i_sum (r_sum_s), .o_avg (avg_s)
    );

    // down test wins over up test when thresholds overlap
    function automatic rcsw_pkg::t_pos classify(
        input logic [rcsw_pkg::CHAN_W-1:0] avg,
        input logic [rcsw_pkg::CHAN_W-1:0] down_below,
        input logic [rcsw_pkg::CHAN_W-1:0] up_above
    );
        rcsw_pkg::t_pos pos;
        priority if (avg < down_below) begin
            pos = rcsw_pkg::POS_DOWN;
        end else if (avg > up_above) begin
            pos = rcsw_pkg::POS_UP;
        end else begin
            pos = rcsw_pkg::POS_MID;
        end
        return pos;
    endfunction

    rcsw_pkg::t_pos                pos_l;
    rcsw_pkg::t_pos                pos_r;
    logic [rcsw_pkg::MODE_W-1:0]   mode;
    logic [rcsw_pkg::BTN_W-1:0]    r_latched;
    logic [rcsw_pkg::BTN_W-1:0]    n_latched;
    rcsw_pkg::t_result             result;

    assign pos_l = classify(avg_l, r_down_below, r_up_above);
    assign pos_r = classify(avg_r, r_down_below, r_up_above);
    assign mode  = ({2'b00, pos_l} << 1) + {2'b00, pos_l} + {2'b00, pos_r};

    always_comb begin
        n_latched       = r_latched;
        n_latched[mode] = avg_s > r_majority;
    end

    assign result = '{mode_index: mode, mode_buttons: n_latched,
                      left_pressed: r_lp[2], right_pressed: r_rp[2],
                      indicator_on: r_lp[2] | r_rp[2], select_average: avg_s};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched <= '0;
        end else if (push) begin
            r_latched <= n_latched;
        end
    end

    // output register with one skid entry
    rcsw_pkg::t_result r_out;
    rcsw_pkg::t_result r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_full <= 1'b0;
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_full <= 1'b1;
            end
        end else if (pop) begin
            if (r_skid_full) begin
                r_skid_full <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            if (!r_out_valid || pop) begin
                r_out <= result;
            end else begin
                r_skid <= result;
            end
        end else if (pop && r_skid_full) begin
            r_out <= r_skid;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_mode_index     = r_out.mode_index;
    assign o_mode_buttons   = r_out.mode_buttons;
    assign o_left_pressed   = r_out.left_pressed;
    assign o_right_pressed  = r_out.right_pressed;
    assign o_indicator_on   = r_out.indicator_on;
    assign o_select_average = r_out.select_average;

    `RCSW_ASSERT(a_skid_needs_out, !r_skid_full || r_out_valid, "skid full with empty output")
    `RCSW_ASSERT(a_mode_range, !r_out_valid || (r_out.mode_index <= 4'd8), "mode index out of range")
    `RCSW_ASSERT_NEXT(a_latch_hold, !push, $stable(r_latched), "mode latch moved without a result")
    `RCSW_ASSERT_NEXT(a_drain, pop && !push && !r_skid_full, !r_out_valid, "output not drained")

endmodule
